// ===== hdl/assert_macros.svh =====
// Assertion macros used by the datapath RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// pre implies post in the same cycle
`define ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// pre implies post in the following cycle
`define ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/vda_pkg.sv =====
// Types, constants and helpers of the voxel deposit aggregator
package vda_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int POS_W           = 24;
   localparam int VOX_W           = 16;
   localparam int DROP_W          = 8;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 24;
   localparam int DIV_STEPS       = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOXEL_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VOXEL_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VOXEL_Z  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_ORIG = 3'd6;

   localparam logic OP_DEPOSIT = 1'b0;
   localparam logic OP_FLUSH   = 1'b1;

   localparam logic [VOX_W-1:0] VOXEL_RST = 16'd300;

   typedef struct packed {
      logic               operation;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [31:0]        energy;
      logic signed [31:0] time_ns;
      logic signed [31:0] track_id;
      logic signed [31:0] original_track_id;
   } req_type;

   typedef struct packed {
      logic signed [23:0] voxel_x_pos;
      logic signed [23:0] voxel_y_pos;
      logic signed [23:0] voxel_z_pos;
      logic [31:0]        summed_energy;
      logic signed [31:0] earliest_time;
      logic signed [31:0] key_track;
      logic               empty_res;
      logic [7:0]         dropped;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [23:0] px;
      logic [23:0] py;
      logic [23:0] pz;
      logic [31:0] track;
      logic [31:0] energy;
      logic [31:0] tns;
   } entry_type;

   typedef struct packed {
      logic div_start;
      logic scan_start;
      logic scan_min;
      logic commit;
      logic emit;
      logic emit_empty;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic scan_done;
      logic out_free;
      logic tbl_empty;
      logic last_one;
   } ctrl_sts_type;

   // signed order on x, y, z, track: flip sign bits, compare unsigned
   function automatic logic key_less(entry_type a, entry_type b);
      logic [103:0] ka;
      logic [103:0] kb;
      ka = {~a.px[23], a.px[22:0], ~a.py[23], a.py[22:0],
            ~a.pz[23], a.pz[22:0], ~a.track[31], a.track[30:0]};
      kb = {~b.px[23], b.px[22:0], ~b.py[23], b.py[22:0],
            ~b.pz[23], b.pz[22:0], ~b.track[31], b.track[30:0]};
      return ka < kb;
   endfunction

endpackage

// ===== hdl/vda_rem.sv =====
// Snap of one coordinate: bit-serial truncating remainder, then subtract
module vda_rem import vda_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [POS_W-1:0] pos,
   input  logic [POS_W-1:0] org,
   input  logic [VOX_W-1:0] vsize,
   output logic             done,
   output logic [POS_W-1:0] snapped
);

   logic [4:0]       cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] mag_ff, mag_in;
   logic [VOX_W-1:0] rem_ff, rem_in;
   logic [VOX_W-1:0] div_ff, div_in;
   logic             neg_ff, neg_in;

   logic [POS_W:0]   diff;
   logic [POS_W:0]   ndiff;
   logic [VOX_W:0]   trial;
   logic [POS_W:0]   rs;

   assign diff  = {pos[POS_W-1], pos} - {org[POS_W-1], org};
   assign ndiff = -diff;
   assign trial = {rem_ff, mag_ff[POS_W-1]};

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      mag_in = mag_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      if (start) begin
         cnt_in = 5'(DIV_STEPS);
         pos_in = pos;
         neg_in = diff[POS_W];
         mag_in = diff[POS_W] ? ndiff[POS_W-1:0] : diff[POS_W-1:0];
         rem_in = '0;
         div_in = (vsize == '0) ? VOX_W'(1) : vsize;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 5'd1;
         mag_in = {mag_ff[POS_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = VOX_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[VOX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      pos_ff <= pos_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   // remainder carries the sign of the difference
   assign rs      = neg_ff ? -{9'd0, rem_ff} : {9'd0, rem_ff};
   assign snapped = POS_W'({pos_ff[POS_W-1], pos_ff} - rs);
   assign done    = (cnt_ff == '0);

endmodule

// ===== hdl/vda_dp.sv =====
// Datapath: config, snap units, entry memory, scan logic, result register
module vda_dp import vda_pkg::*; #(
   parameter int DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  ctrl_cmd_type          cmd,
   output ctrl_sts_type          sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

`include "assert_macros.svh"

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   // configuration
   logic [POS_W-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic [POS_W-1:0] org_x_in, org_y_in, org_z_in;
   logic [VOX_W-1:0] vox_x_ff, vox_y_ff, vox_z_ff;
   logic [VOX_W-1:0] vox_x_in, vox_y_in, vox_z_in;
   logic             use_orig_ff, use_orig_in;

   always_comb begin
      org_x_in    = org_x_ff;
      org_y_in    = org_y_ff;
      org_z_in    = org_z_ff;
      vox_x_in    = vox_x_ff;
      vox_y_in    = vox_y_ff;
      vox_z_in    = vox_z_ff;
      use_orig_in = use_orig_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X: org_x_in    = csr_wdata;
            CSR_ORIGIN_Y: org_y_in    = csr_wdata;
            CSR_ORIGIN_Z: org_z_in    = csr_wdata;
            CSR_VOXEL_X:  vox_x_in    = csr_wdata[VOX_W-1:0];
            CSR_VOXEL_Y:  vox_y_in    = csr_wdata[VOX_W-1:0];
            CSR_VOXEL_Z:  vox_z_in    = csr_wdata[VOX_W-1:0];
            CSR_USE_ORIG: use_orig_in = csr_wdata[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff    <= '0;
         org_y_ff    <= '0;
         org_z_ff    <= '0;
         vox_x_ff    <= VOXEL_RST;
         vox_y_ff    <= VOXEL_RST;
         vox_z_ff    <= VOXEL_RST;
         use_orig_ff <= 1'b1;
      end else begin
         org_x_ff    <= org_x_in;
         org_y_ff    <= org_y_in;
         org_z_ff    <= org_z_in;
         vox_x_ff    <= vox_x_in;
         vox_y_ff    <= vox_y_in;
         vox_z_ff    <= vox_z_in;
         use_orig_ff <= use_orig_in;
      end
   end

   // deposit capture and snapping
   logic [31:0]      energy_ff, energy_in;
   logic [31:0]      tns_ff, tns_in;
   logic [31:0]      track_ff, track_in;
   logic [POS_W-1:0] sx, sy, sz;
   logic             done_x, done_y, done_z;
   entry_type        nent;

   assign energy_in = cmd.div_start ? req_data.energy : energy_ff;
   assign tns_in    = cmd.div_start ? req_data.time_ns : tns_ff;
   assign track_in  = !cmd.div_start ? track_ff :
                      (use_orig_ff ? req_data.original_track_id : req_data.track_id);

   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
      tns_ff    <= tns_in;
      track_ff  <= track_in;
   end

   vda_rem u_rem_x (
      .clock(clock), .reset(reset), .start(cmd.div_start), .pos(req_data.pos_x),
      .org(org_x_ff), .vsize(vox_x_ff), .done(done_x), .snapped(sx)
   );
   vda_rem u_rem_y (
      .clock(clock), .reset(reset), .start(cmd.div_start), .pos(req_data.pos_y),
      .org(org_y_ff), .vsize(vox_y_ff), .done(done_y), .snapped(sy)
   );
   vda_rem u_rem_z (
      .clock(clock), .reset(reset), .start(cmd.div_start), .pos(req_data.pos_z),
      .org(org_z_ff), .vsize(vox_z_ff), .done(done_z), .snapped(sz)
   );

   assign nent = '{px: sx, py: sy, pz: sz, track: track_ff,
                   energy: energy_ff, tns: tns_ff};

   // entry memory, registered read
   entry_type       mem [DEPTH];
   entry_type       rd_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   entry_type       mem_wdata;
   logic [AW-1:0]   sidx_ff, sidx_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[sidx_ff];
   end

   // scan and table state
   logic             issue_ff, issue_in;
   logic             rdv_ff, rdv_in;
   logic [AW-1:0]    ridx_ff, ridx_in;
   logic             scan_min_ff, scan_min_in;
   logic             found_ff, found_in;
   logic [AW-1:0]    hit_idx_ff, hit_idx_in;
   entry_type        hit_ff, hit_in;
   logic             free_ok_ff, free_ok_in;
   logic [AW-1:0]    free_idx_ff, free_idx_in;
   logic [DEPTH-1:0] vbit_ff, vbit_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             rd_vbit;
   logic             key_eq;
   logic [32:0]      esum;

   assign rd_vbit = vbit_ff[ridx_ff];
   assign key_eq  = (rd_ff.px == nent.px) && (rd_ff.py == nent.py) &&
                    (rd_ff.pz == nent.pz) && (rd_ff.track == nent.track);
   assign esum    = {1'b0, hit_ff.energy} + {1'b0, energy_ff};

   always_comb begin
      sidx_in      = sidx_ff;
      issue_in     = issue_ff;
      rdv_in       = issue_ff;
      ridx_in      = sidx_ff;
      scan_min_in  = scan_min_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_in       = hit_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      vbit_in      = vbit_ff;
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = hit_idx_ff;
      mem_wdata    = nent;

      if (issue_ff) begin
         if (sidx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end else begin
            sidx_in = sidx_ff + AW'(1);
         end
      end

      if (rdv_ff) begin
         if (scan_min_ff) begin
            if (rd_vbit && (!found_ff || key_less(rd_ff, hit_ff))) begin
               found_in   = 1'b1;
               hit_idx_in = ridx_ff;
               hit_in     = rd_ff;
            end
         end else begin
            if (rd_vbit && key_eq) begin
               found_in   = 1'b1;
               hit_idx_in = ridx_ff;
               hit_in     = rd_ff;
            end
            if (!rd_vbit && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = ridx_ff;
            end
         end
      end

      if (cmd.scan_start) begin
         issue_in    = 1'b1;
         sidx_in     = '0;
         rdv_in      = 1'b0;
         found_in    = 1'b0;
         free_ok_in  = 1'b0;
         scan_min_in = cmd.scan_min;
      end

      if (cmd.commit) begin
         if (found_ff) begin
            mem_we           = 1'b1;
            mem_waddr        = hit_idx_ff;
            mem_wdata        = hit_ff;
            mem_wdata.energy = esum[32] ? '1 : esum[31:0];
            if ($signed(tns_ff) < $signed(hit_ff.tns)) begin
               mem_wdata.tns = tns_ff;
            end
         end else if (free_ok_ff) begin
            mem_we               = 1'b1;
            mem_waddr            = free_idx_ff;
            vbit_in[free_idx_ff] = 1'b1;
            cnt_in               = cnt_ff + CW'(1);
         end else if (drop_ff != '1) begin
            drop_in = drop_ff + DROP_W'(1);
         end
      end

      if (cmd.emit) begin
         vbit_in[hit_idx_ff] = 1'b0;
         cnt_in              = cnt_ff - CW'(1);
         rsp_valid_in        = 1'b1;
         rsp_in = '{voxel_x_pos: hit_ff.px, voxel_y_pos: hit_ff.py,
                    voxel_z_pos: hit_ff.pz, summed_energy: hit_ff.energy,
                    earliest_time: hit_ff.tns, key_track: hit_ff.track,
                    empty_res: 1'b0, dropped: drop_ff, last: (cnt_ff == CW'(1))};
         if (cnt_ff == CW'(1)) begin
            drop_in = '0;
         end
      end

      if (cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
         rsp_in = '{voxel_x_pos: '0, voxel_y_pos: '0, voxel_z_pos: '0,
                    summed_energy: '0, earliest_time: '0, key_track: '0,
                    empty_res: 1'b1, dropped: drop_ff, last: 1'b1};
         drop_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         scan_min_ff  <= 1'b0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         vbit_ff      <= '0;
         cnt_ff       <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         issue_ff     <= issue_in;
         rdv_ff       <= rdv_in;
         scan_min_ff  <= scan_min_in;
         found_ff     <= found_in;
         free_ok_ff   <= free_ok_in;
         vbit_ff      <= vbit_in;
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sidx_ff     <= sidx_in;
      ridx_ff     <= ridx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ff      <= hit_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.div_done  = done_x && done_y && done_z;
   assign sts.scan_done = rdv_ff && (ridx_ff == LAST_IDX);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.tbl_empty = (cnt_ff == '0);
   assign sts.last_one  = (cnt_ff == CW'(1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLY(a_emit_room, cmd.emit || cmd.emit_empty, sts.out_free, "result overwritten")
   `ASSERT_ALWAYS(a_cnt_range, cnt_ff <= CW'(DEPTH), "entry count beyond table depth")
   `ASSERT_NEXT(a_min_found, scan_min_ff && sts.scan_done, found_ff, "flush scan found no entry")

endmodule

// ===== hdl/vda_ctrl.sv =====
// Controller: sequences snap, table scan, commit and sorted flush
module vda_ctrl import vda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_op,
   output logic         req_stall,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DIV    = 6'b000010,
      S_SCAN   = 6'b000100,
      S_COMMIT = 6'b001000,
      S_FSCAN  = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      empty_ff, empty_in;   // flush of an empty table

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      empty_in = empty_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_DEPOSIT) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end else if (sts.tbl_empty) begin
                  empty_in = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  empty_in       = 1'b0;
                  cmd.scan_start = 1'b1;
                  cmd.scan_min   = 1'b1;
                  state_in       = S_FSCAN;
               end
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         S_FSCAN: begin
            if (sts.scan_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               if (empty_ff) begin
                  cmd.emit_empty = 1'b1;
                  state_in       = S_IDLE;
               end else if (sts.last_one) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.emit       = 1'b1;
                  cmd.scan_start = 1'b1;
                  cmd.scan_min   = 1'b1;
                  state_in       = S_FSCAN;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         empty_ff <= empty_in;
      end
   end

endmodule

// ===== hdl/voxel_deposit_aggregator.sv =====
// Top level of the voxel deposit aggregator
//
// Collects energy deposits into a table of up to TABLE_DEPTH voxel entries,
// keyed on the snapped point and a track id, and on a flush item hands the
// entries out sorted by x, y, z and track (all signed), one result item
// each, the final one marked last; an empty table gives a single result
// with empty_res set. A deposit gives no result. A deposit first runs the
// bit-serial remainder units that snap the three axes in parallel, then
// one pass over the entry memory and a commit step. In a flush every
// sorted item comes from a full pass over the memory for the smallest
// remaining key, and the flush stalls further while the result register
// is not taken. The block takes one item at a time; req_stall is high
// while an item is in work. Configuration is written through
// csr_we/csr_index/csr_wdata; the user must write it only while idle,
// and the block itself does not enforce this.
//
module voxel_deposit_aggregator import vda_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // deposit and flush items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   vda_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_data.operation),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   vda_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
